FILE: hdl/smbe_pkg.sv
// smbe_pkg: shared widths, register indexes and field layout for the SPI master
// byte engine. No dependencies; used by hdl/spi_master_byte_engine.sv.
package smbe_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd1;

    localparam int MODE_W = 2;
    localparam int HALF_W = 10;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
    localparam logic [HALF_W-1:0] HALF_RESET = 10'd10;

    // stream payload widths
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 16;

    localparam int BYTE_W = 8;
    localparam int BIT_W  = 3;

    localparam logic [BIT_W-1:0] BIT_FIRST = 3'd7;
    localparam logic [BIT_W-1:0] BIT_LAST  = 3'd0;

    // command codes carried in tuser
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic [2:0]        pad;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              select_n;
        logic              mosi_level;
        logic              sck_level;
    } t_result;

endpackage

FILE: hdl/spi_master_byte_engine.sv
// spi_master_byte_engine: CPOL/CPHA mode 0..3 SPI master, one byte per transfer,
// one input item per pin-level tick. Depends on hdl/smbe_pkg.sv.
// Each result is registered on the edge that accepts its tick. Throughput: one
// tick per cycle unless a result waits on a stalled sink; the state step and
// output register update on the same edge, and a new tick is taken while the
// output register drains. A byte transfer spans (17 * half_period_ticks + 1)
// ticks of input items. Reset (i_rst_n low, synchronous): idle, select high, SCK
// and MOSI low, mode 0, half period 10, no result pending.
module spi_master_byte_engine #(
    parameter int DIVIDER_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smbe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smbe_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // tick stream in
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] tx_byte, [8] miso_level, [15:9] zero
    input  logic [smbe_pkg::S_DATA_W-1:0]       s_axis_tdata,
    // [0] command
    input  logic [smbe_pkg::S_USER_W-1:0]       s_axis_tuser,
    // result stream out
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] sck_level, [1] mosi_level, [2] select_n, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [15:13] zero
    output logic [smbe_pkg::M_DATA_W-1:0]       m_axis_tdata
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SETUP  = 2'd1;
    localparam logic [1:0] PH_FIRST  = 2'd2;
    localparam logic [1:0] PH_SECOND = 2'd3;

    localparam logic [DIVIDER_BITS-1:0] WAIT_ONE  = DIVIDER_BITS'(1);
    localparam logic [DIVIDER_BITS-1:0] WAIT_ZERO = '0;

    // configuration registers
    logic [smbe_pkg::MODE_W-1:0] r_mode;
    logic [smbe_pkg::HALF_W-1:0] r_half;

    // sequencer state
    logic [1:0]                       r_phase, n_phase;
    logic [smbe_pkg::BIT_W-1:0]       r_bit, n_bit;
    logic [DIVIDER_BITS-1:0]          r_wait, n_wait;
    logic [smbe_pkg::BYTE_W-1:0]      r_tx, n_tx;
    logic [smbe_pkg::BYTE_W-1:0]      r_rx, n_rx;
    logic                             r_sck, n_sck;
    logic                             r_mosi, n_mosi;
    logic                             r_select, n_select;

    // output register
    logic                             r_out_valid;
    smbe_pkg::t_result                r_out, n_out;

    logic                             w_accept;
    logic                             w_cmd;
    logic [smbe_pkg::BYTE_W-1:0]      w_tx_byte;
    logic                             w_miso;
    logic                             w_cpol, w_cpha;
    logic [DIVIDER_BITS-1:0]          w_half_raw, w_half;
    logic [DIVIDER_BITS-1:0]          w_dec;
    logic                             w_done;
    logic [smbe_pkg::BYTE_W-1:0]      w_rx_out;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_cmd     = s_axis_tuser[0];
    assign w_tx_byte = s_axis_tdata[7:0];
    assign w_miso    = s_axis_tdata[8];

    assign w_cpol = r_mode[1];
    assign w_cpha = r_mode[0];

    // half period taken in the divider width, zero counts as one
    assign w_half_raw = DIVIDER_BITS'(r_half);
    assign w_half     = (w_half_raw == WAIT_ZERO) ? WAIT_ONE : w_half_raw;
    assign w_dec      = r_wait - WAIT_ONE;

    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_wait   = r_wait;
        n_tx     = r_tx;
        n_rx     = r_rx;
        n_sck    = r_sck;
        n_mosi   = r_mosi;
        n_select = r_select;
        w_done   = 1'b0;
        w_rx_out = '0;

        if (r_phase == PH_IDLE) begin
            if (w_cmd == smbe_pkg::CMD_START) begin
                n_tx     = w_tx_byte;
                n_rx     = '0;
                n_bit    = smbe_pkg::BIT_FIRST;
                n_sck    = w_cpol;
                n_select = 1'b0;
                n_wait   = w_half;
                n_phase  = PH_SETUP;
            end
        end else begin
            n_wait = w_dec;
            if (w_dec == WAIT_ZERO) begin
                n_wait = w_half;
                unique case (r_phase)
                    PH_SETUP: begin
                        n_mosi  = r_tx[r_bit];
                        n_sck   = w_cpol ^ w_cpha;
                        n_phase = PH_FIRST;
                    end
                    PH_FIRST: begin
                        // sampling edge
                        n_sck   = !w_cpol ^ w_cpha;
                        n_rx    = {r_rx[smbe_pkg::BYTE_W-2:0], w_miso};
                        n_phase = PH_SECOND;
                    end
                    default: begin
                        n_sck = w_cpol;
                        if (r_bit == smbe_pkg::BIT_LAST) begin
                            n_select = 1'b1;
                            w_done   = 1'b1;
                            w_rx_out = r_rx;
                            n_bit    = smbe_pkg::BIT_FIRST;
                            n_wait   = WAIT_ZERO;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_bit   = r_bit - 3'd1;
                            n_mosi  = r_tx[n_bit];
                            n_sck   = w_cpol ^ w_cpha;
                            n_phase = PH_FIRST;
                        end
                    end
                endcase
            end
        end

        n_out            = '0;
        n_out.sck_level  = n_sck;
        n_out.mosi_level = n_mosi;
        n_out.select_n   = n_select;
        n_out.busy_res   = (n_phase != PH_IDLE);
        n_out.done_res   = w_done;
        n_out.rx_byte    = w_rx_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= smbe_pkg::MODE_RESET;
            r_half <= smbe_pkg::HALF_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                smbe_pkg::REG_CLOCK_MODE:  r_mode <= i_cfg_data[smbe_pkg::MODE_W-1:0];
                smbe_pkg::REG_HALF_PERIOD: r_half <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bit    <= smbe_pkg::BIT_FIRST;
            r_wait   <= WAIT_ZERO;
            r_tx     <= '0;
            r_rx     <= '0;
            r_sck    <= 1'b0;
            r_mosi   <= 1'b0;
            r_select <= 1'b1;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_bit    <= n_bit;
            r_wait   <= n_wait;
            r_tx     <= n_tx;
            r_rx     <= n_rx;
            r_sck    <= n_sck;
            r_mosi   <= n_mosi;
            r_select <= n_select;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload holds while a result waits
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // a finished transfer always leaves the slave deselected and the engine idle
    a_done_deselects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> (r_out.select_n && !r_out.busy_res))
        else $error("done reported with select low or busy set");

    // select is low exactly while a transfer is in progress
    a_select_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) == !r_select)
        else $error("chip select disagrees with sequencer phase");

    // idle sequencer is parked with the counter cleared and the bit index at the MSB
    a_idle_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_wait == WAIT_ZERO && r_bit == smbe_pkg::BIT_FIRST))
        else $error("idle sequencer not parked");

    // the counter never rests at zero during a transfer
    a_wait_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_wait != WAIT_ZERO))
        else $error("half-period counter at zero while busy");

endmodule

FILE: verif/tb_spi_master_byte_engine.sv
`timescale 1ns / 100ps
// tb_spi_master_byte_engine: self-checking bench for the SPI master byte engine, with a
// cycle-accurate pin predictor, bursty tick traffic and a stalling result sink.
// Depends on hdl/smbe_pkg.sv and hdl/spi_master_byte_engine.sv.
module tb_spi_master_byte_engine;

    localparam int MODE_W     = smbe_pkg::MODE_W;
    localparam int HALF_W     = smbe_pkg::HALF_W;
    localparam int BIT_W      = smbe_pkg::BIT_W;
    localparam int BYTE_W     = smbe_pkg::BYTE_W;
    localparam int CFG_IDX_W  = smbe_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = smbe_pkg::CFG_DATA_W;
    localparam int S_DATA_W   = smbe_pkg::S_DATA_W;
    localparam int S_USER_W   = smbe_pkg::S_USER_W;
    localparam int M_DATA_W   = smbe_pkg::M_DATA_W;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_TICKS   = 60;
    localparam int QUIET_TICKS   = 40;
    localparam int SLOW_HALF     = 1023;
    localparam int SLOW_TICKS    = 60;
    localparam int HOLD_AT       = 120;
    localparam int HOLD_CYCLES   = 500;

    localparam logic [MODE_W-1:0] PHASE_MODE [8] = '{2'd1, 2'd2, 2'd3, 2'd0,
                                                     2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [HALF_W-1:0] PHASE_HALF [8] = '{10'd1, 10'd2, 10'd1, 10'd3,
                                                     10'd5, 10'd10, 10'd4, 10'd2};

    typedef enum logic [1:0] {
        XF_IDLE,
        XF_SETUP,
        XF_FIRST,
        XF_SECOND
    } t_xfer_phase;

    class spi_pin_scoreboard;
        logic [MODE_W-1:0]  clock_mode;
        logic [HALF_W-1:0]  half_ticks;
        t_xfer_phase        phase;
        logic [BIT_W-1:0]   bit_idx;
        logic [HALF_W-1:0]  wait_cnt;
        logic [BYTE_W-1:0]  tx_sr;
        logic [BYTE_W-1:0]  rx_sr;
        logic               sck_q;
        logic               mosi_q;
        logic               cs_n_q;
        smbe_pkg::t_result  pin_levels_q [$];
        int                 errors;
        int                 checked;

        function new();
            clock_mode = smbe_pkg::MODE_RESET;
            half_ticks = smbe_pkg::HALF_RESET;
            phase      = XF_IDLE;
            bit_idx    = smbe_pkg::BIT_FIRST;
            wait_cnt   = '0;
            tx_sr      = '0;
            rx_sr      = '0;
            sck_q      = 1'b0;
            mosi_q     = 1'b0;
            cs_n_q     = 1'b1;
            errors     = 0;
            checked    = 0;
        endfunction

        function int pending();
            return pin_levels_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == smbe_pkg::REG_CLOCK_MODE) begin
                clock_mode = val[MODE_W-1:0];
            end else if (idx == smbe_pkg::REG_HALF_PERIOD) begin
                half_ticks = val[HALF_W-1:0];
            end
        endfunction

        // a zero half period runs as one tick
        function logic [HALF_W-1:0] half_len();
            return (half_ticks == '0) ? HALF_W'(1) : half_ticks;
        endfunction

        function void launch_bit(logic cpol, logic cpha);
            mosi_q = tx_sr[bit_idx];
            sck_q  = cpol ^ cpha;
            phase  = XF_FIRST;
        endfunction

        function void note_tick(logic cmd, logic [BYTE_W-1:0] txb, logic miso);
            smbe_pkg::t_result want;
            logic    cpol;
            logic    cpha;
            want = '0;
            cpol = clock_mode[1];
            cpha = clock_mode[0];
            if (phase == XF_IDLE) begin
                // a start while busy never reaches here, so its byte is dropped
                if (cmd == smbe_pkg::CMD_START) begin
                    tx_sr    = txb;
                    rx_sr    = '0;
                    bit_idx  = smbe_pkg::BIT_FIRST;
                    sck_q    = cpol;
                    cs_n_q   = 1'b0;
                    wait_cnt = half_len();
                    phase    = XF_SETUP;
                end
            end else begin
                wait_cnt = wait_cnt - 1'b1;
                if (wait_cnt == '0) begin
                    wait_cnt = half_len();
                    case (phase)
                        XF_SETUP: begin
                            launch_bit(cpol, cpha);
                        end
                        XF_FIRST: begin
                            sck_q = (~cpol) ^ cpha;
                            rx_sr = {rx_sr[BYTE_W-2:0], miso};
                            phase = XF_SECOND;
                        end
                        default: begin
                            sck_q = cpol;
                            if (bit_idx == smbe_pkg::BIT_LAST) begin
                                cs_n_q         = 1'b1;
                                want.done_res  = 1'b1;
                                want.rx_byte   = rx_sr;
                                bit_idx        = smbe_pkg::BIT_FIRST;
                                wait_cnt       = '0;
                                phase          = XF_IDLE;
                            end else begin
                                bit_idx = bit_idx - 1'b1;
                                launch_bit(cpol, cpha);
                            end
                        end
                    endcase
                end
            end
            want.sck_level  = sck_q;
            want.mosi_level = mosi_q;
            want.select_n   = cs_n_q;
            want.busy_res   = (phase != XF_IDLE);
            pin_levels_q.push_back(want);
        endfunction

        task flag_mismatch(string what);
            if (errors < 40) begin
                $display("%0t: mismatch after %0d results: %s", $time, checked, what);
            end
            errors++;
        endtask

        task check_pins(logic [M_DATA_W-1:0] data);
            smbe_pkg::t_result got;
            smbe_pkg::t_result want;
            got = data;
            if (pin_levels_q.size() == 0) begin
                flag_mismatch($sformatf("result 0x%04h with nothing expected", data));
                return;
            end
            want = pin_levels_q.pop_front();
            checked++;
            if (got.sck_level !== want.sck_level)
                flag_mismatch($sformatf("sck %b, want %b", got.sck_level, want.sck_level));
            if (got.mosi_level !== want.mosi_level)
                flag_mismatch($sformatf("mosi %b, want %b", got.mosi_level, want.mosi_level));
            if (got.select_n !== want.select_n)
                flag_mismatch($sformatf("select_n %b, want %b", got.select_n, want.select_n));
            if (got.busy_res !== want.busy_res)
                flag_mismatch($sformatf("busy %b, want %b", got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                flag_mismatch($sformatf("done %b, want %b", got.done_res, want.done_res));
            if (got.rx_byte !== want.rx_byte)
                flag_mismatch($sformatf("rx_byte 0x%02h, want 0x%02h", got.rx_byte,
                                        want.rx_byte));
            if (got.pad !== 3'd0)
                flag_mismatch($sformatf("padding bits %b not zero", got.pad));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [S_USER_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;

    spi_pin_scoreboard sb;

    int                burst_left;
    int                gen_busy_left;
    logic [HALF_W-1:0] cur_half;
    int                cycles;
    int                hold_left;
    bit                hold_used;
    int                seg_left;
    int                seg_mode;

    spi_master_byte_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("spi_master_byte_engine verification failed");
            $finish;
        end
    end

    // one monitor for all channels keeps register writes, ticks and results in order
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.set_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_tick(s_axis_tuser[0], s_axis_tdata[BYTE_W-1:0], s_axis_tdata[BYTE_W]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pins(m_axis_tdata);
        end
    end

    // result sink: random segments of full rate, random stalls and sparse ready,
    // plus one long hold-off so the engine backs up into its input
    always @(posedge i_clk) begin
        if (hold_left == 0 && !hold_used && sb != null && sb.checked >= HOLD_AT) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_mode = $urandom_range(0, 2);
                seg_left = $urandom_range(4, 80);
            end
            seg_left--;
            case (seg_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= (seg_left % 3 == 0);
            endcase
        end
    end

    task automatic send_tick(input logic cmd, input logic [BYTE_W-1:0] txb,
                             input logic miso);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_DATA_W-BYTE_W-1){1'b0}}, miso, txb};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // mostly starts on an idle engine, with the odd start while busy as noise
    task automatic rand_tick();
        logic cmd;
        if (gen_busy_left != 0) begin
            cmd = ($urandom_range(0, 19) == 0) ? smbe_pkg::CMD_START : smbe_pkg::CMD_TICK;
            gen_busy_left--;
        end else begin
            cmd = ($urandom_range(0, 9) < 6) ? smbe_pkg::CMD_START : smbe_pkg::CMD_TICK;
            if (cmd == smbe_pkg::CMD_START)
                gen_busy_left = 17 * ((cur_half == '0) ? 1 : int'(cur_half));
        end
        send_tick(cmd, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input logic [HALF_W-1:0] half);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= smbe_pkg::REG_CLOCK_MODE;
        i_cfg_data  <= CFG_DATA_W'(mode);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= smbe_pkg::REG_HALF_PERIOD;
        i_cfg_data  <= CFG_DATA_W'(half);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_half = half;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= smbe_pkg::CMD_TICK;
        m_axis_tready <= 1'b0;
        burst_left    = 0;
        gen_busy_left = 0;
        cur_half      = smbe_pkg::HALF_RESET;
        cycles        = 0;
        hold_left     = 0;
        hold_used     = 1'b0;
        seg_left      = 0;
        seg_mode      = 0;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero half period, all-ones byte in and out, start while busy
        set_config(2'd0, '0);
        send_tick(smbe_pkg::CMD_TICK, 8'hFF, 1'b1);
        send_tick(smbe_pkg::CMD_START, 8'hFF, 1'b0);
        for (int k = 0; k < 17; k++) begin
            if (k == 4)
                send_tick(smbe_pkg::CMD_START, 8'h00, 1'b1);
            else
                send_tick(smbe_pkg::CMD_TICK, 8'h00, 1'b1);
        end
        send_tick(smbe_pkg::CMD_TICK, 8'h00, 1'b0);
        send_tick(smbe_pkg::CMD_TICK, 8'hFF, 1'b0);
        drain();

        // random phases over all modes; some end mid-transfer before the next write
        for (int p = 0; p < 8; p++) begin
            set_config(PHASE_MODE[p], PHASE_HALF[p]);
            for (int k = 0; k < PHASE_TICKS; k++)
                rand_tick();
            drain();
        end

        // let any transfer finish before the slowest setting
        for (int k = 0; k < QUIET_TICKS; k++)
            send_tick(smbe_pkg::CMD_TICK, BYTE_W'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        drain();
        set_config(2'd3, HALF_W'(SLOW_HALF));
        gen_busy_left = 0;
        for (int k = 0; k < SLOW_TICKS; k++)
            rand_tick();
        drain();
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("spi_master_byte_engine verification clean");
        end else begin
            $display("spi_master_byte_engine verification failed");
        end
        $finish;
    end

endmodule
